// ===== rtl/core/clc_pkg.sv =====
// shared types and constants for the content-length deframer
// no dependencies; imported by clc_front, clc_queue and the top level
`timescale 1ns / 1ps

package clc_pkg;

    // characters the header tracker looks for
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UPA   = 8'h41;
    localparam logic [7:0] CH_UPZ   = 8'h5A;

    // length of the "content-length:" tag
    localparam int unsigned TAG_LEN = 15;
    localparam logic [3:0]  TAG_LAST = 4'(TAG_LEN - 1);

    // phase of the length field search
    typedef enum logic [1:0] {
        PH_TAG    = 2'd0,
        PH_SPACE  = 2'd1,
        PH_DIGITS = 2'd2,
        PH_DONE   = 2'd3
    } t_phase;

    // separator progress: bytes of CR LF CR LF matched so far
    typedef enum logic [1:0] {
        SEP_NONE   = 2'd0,
        SEP_CR     = 2'd1,
        SEP_CRLF   = 2'd2,
        SEP_CRLFCR = 2'd3
    } t_sep;

    // one result transaction
    typedef struct packed {
        logic [7:0] body_byte;
        logic       last;
        logic       empty_msg;
    } t_result;

    // lowercase tag characters by position
    function automatic logic [7:0] tag_char(input logic [3:0] idx);
        logic [7:0] c;
        case (idx)
            4'd0:    c = 8'h63; // c
            4'd1:    c = 8'h6F; // o
            4'd2:    c = 8'h6E; // n
            4'd3:    c = 8'h74; // t
            4'd4:    c = 8'h65; // e
            4'd5:    c = 8'h6E; // n
            4'd6:    c = 8'h74; // t
            4'd7:    c = 8'h2D; // -
            4'd8:    c = 8'h6C; // l
            4'd9:    c = 8'h65; // e
            4'd10:   c = 8'h6E; // n
            4'd11:   c = 8'h67; // g
            4'd12:   c = 8'h74; // t
            4'd13:   c = 8'h68; // h
            4'd14:   c = 8'h3A; // :
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

// ===== rtl/core/clc_front.sv =====
// front end: tracks header tag, length digits and separator, counts body bytes
// depends on clc_pkg; pushes result transactions into clc_queue
`timescale 1ns / 1ps

module clc_front #(
    parameter int LEN_BITS = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic [7:0]       i_byte,
    output logic             o_push,
    output clc_pkg::t_result o_result
);
    import clc_pkg::*;

    localparam logic [LEN_BITS-1:0] LEN_ONE = LEN_BITS'(1);

    logic                r_in_body, n_in_body;
    t_sep                r_sep, n_sep;
    logic [3:0]          r_tag, n_tag;
    t_phase              r_phase, n_phase;
    logic [LEN_BITS-1:0] r_len, n_len;
    logic [LEN_BITS-1:0] r_left, n_left;

    logic [7:0]          lower;
    logic                is_digit;
    logic [LEN_BITS+3:0] len_ext;
    logic [LEN_BITS+3:0] len_acc;
    logic [LEN_BITS-1:0] len_digit;
    logic                sep_done;

    // lowercase and digit decode of the incoming byte
    assign lower    = (i_byte >= CH_UPA && i_byte <= CH_UPZ) ? i_byte + 8'd32 : i_byte;
    assign is_digit = (i_byte >= CH_ZERO) && (i_byte <= CH_NINE);

    // len * 10 + digit, saturating at the largest length
    assign len_ext   = {4'b0000, r_len};
    assign len_acc   = (len_ext << 3) + (len_ext << 1) + {{LEN_BITS{1'b0}}, i_byte[3:0]};
    assign len_digit = (len_acc[LEN_BITS+3:LEN_BITS] != 4'b0000) ? {LEN_BITS{1'b1}}
                                                                   : len_acc[LEN_BITS-1:0];

    assign sep_done = (r_sep == SEP_CRLFCR) && (i_byte == CH_LF);

    // next state of the tag and length tracker
    always_comb begin
        n_phase = r_phase;
        n_tag   = r_tag;
        n_len   = r_len;
        unique case (r_phase)
            PH_TAG: begin
                if (lower == tag_char(r_tag)) begin
                    if (r_tag == TAG_LAST) begin
                        n_tag   = 4'd0;
                        n_phase = PH_SPACE;
                    end else begin
                        n_tag = r_tag + 4'd1;
                    end
                end else begin
                    n_tag = (lower == tag_char(4'd0)) ? 4'd1 : 4'd0;
                end
            end
            PH_SPACE: begin
                if (i_byte != CH_SPACE) begin
                    if (is_digit) begin
                        n_phase = PH_DIGITS;
                        n_len   = len_digit;
                    end else begin
                        n_phase = PH_DONE;
                    end
                end
            end
            PH_DIGITS: begin
                if (is_digit) begin
                    n_len = len_digit;
                end else begin
                    n_phase = PH_DONE;
                end
            end
            PH_DONE: begin
                n_phase = PH_DONE;
            end
            default: begin
                n_phase = PH_TAG;
            end
        endcase
    end

    // next state of the separator matcher
    always_comb begin
        if ((r_sep == SEP_NONE || r_sep == SEP_CRLF) && i_byte == CH_CR) begin
            n_sep = (r_sep == SEP_NONE) ? SEP_CR : SEP_CRLFCR;
        end else if (r_sep == SEP_CR && i_byte == CH_LF) begin
            n_sep = SEP_CRLF;
        end else if (sep_done) begin
            n_sep = SEP_NONE;
        end else begin
            n_sep = (i_byte == CH_CR) ? SEP_CR : SEP_NONE;
        end
    end

    // result output and body counter
    always_comb begin
        o_push             = 1'b0;
        o_result.body_byte = i_byte;
        o_result.last      = 1'b0;
        o_result.empty_msg = 1'b0;
        n_in_body          = r_in_body;
        n_left             = r_left;
        if (r_in_body) begin
            o_push        = 1'b1;
            o_result.last = (r_left == LEN_ONE);
            n_left        = r_left - LEN_ONE;
            if (r_left == LEN_ONE) begin
                n_in_body = 1'b0;
            end
        end else if (sep_done) begin
            if (r_len == '0) begin
                o_push             = 1'b1;
                o_result.body_byte = 8'h00;
                o_result.last      = 1'b1;
                o_result.empty_msg = 1'b1;
            end else begin
                n_in_body = 1'b1;
                n_left    = r_len;
            end
        end
        if (!i_accept) begin
            o_push = 1'b0;
        end
    end

    // state registers; header trackers clear when a header completes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_body <= 1'b0;
            r_sep     <= SEP_NONE;
            r_tag     <= 4'd0;
            r_phase   <= PH_TAG;
            r_len     <= '0;
            r_left    <= '0;
        end else if (i_accept) begin
            r_in_body <= n_in_body;
            r_left    <= n_left;
            if (!r_in_body) begin
                if (sep_done) begin
                    r_sep   <= SEP_NONE;
                    r_tag   <= 4'd0;
                    r_phase <= PH_TAG;
                    r_len   <= '0;
                end else begin
                    r_sep   <= n_sep;
                    r_tag   <= n_tag;
                    r_phase <= n_phase;
                    r_len   <= n_len;
                end
            end
        end
    end

endmodule

// ===== rtl/core/clc_queue.sv =====
// back end: two-entry result queue with a registered head driving the output
// depends on clc_pkg; fed by clc_front
`timescale 1ns / 1ps

module clc_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  clc_pkg::t_result i_result,
    output logic             o_space,
    output logic             o_valid,
    input  logic             i_ready,
    output clc_pkg::t_result o_result
);
    import clc_pkg::*;

    logic [1:0] r_cnt, n_cnt;
    t_result    r_head, n_head;
    t_result    r_spill, n_spill;
    logic       pop;

    assign o_valid  = (r_cnt != 2'd0);
    assign o_space  = (r_cnt != 2'd2);
    assign o_result = r_head;
    assign pop      = o_valid && i_ready;

    // queue update for push, pop or both
    always_comb begin
        n_cnt   = r_cnt;
        n_head  = r_head;
        n_spill = r_spill;
        case ({i_push, pop})
            2'b11: begin
                if (r_cnt == 2'd2) begin
                    n_head  = r_spill;
                    n_spill = i_result;
                end else begin
                    n_head = i_result;
                end
            end
            2'b10: begin
                n_cnt = r_cnt + 2'd1;
                if (r_cnt == 2'd0) begin
                    n_head = i_result;
                end else begin
                    n_spill = i_result;
                end
            end
            2'b01: begin
                n_cnt  = r_cnt - 2'd1;
                n_head = r_spill;
            end
            default: begin
                n_cnt = r_cnt;
            end
        endcase
    end

    // fill count under reset, payload without
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_head  <= n_head;
        r_spill <= n_spill;
    end

endmodule

// ===== rtl/core/content_length_deframer_unit.sv =====
// top level of the content-length deframer: front end plus result queue
// depends on clc_pkg, clc_front and clc_queue
`timescale 1ns / 1ps

// Byte-stream deframer for "Content-Length" framed messages. Each input
// transaction carries one stream byte. Header bytes are scanned for the first
// case-insensitive "content-length:" tag; spaces after it are skipped and the
// decimal digits that follow set the body length, saturating at 2^LEN_BITS-1
// (no digits means length 0). CR LF CR LF ends the header; the next length
// bytes then come out one per result, the final one with o_last set. A zero
// length gives a single result with o_empty_msg and o_last set and a zero
// byte. Header bytes give no result. One byte is taken every cycle while
// o_ready is high: the tracker does its work in the cycle a byte is accepted,
// and a two-entry result queue behind it keeps o_ready high unless two wait.
module content_length_deframer_unit #(
    parameter int LEN_BITS = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_in_byte,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_body_byte,
    output logic       o_last,
    output logic       o_empty_msg
);
    import clc_pkg::*;

    logic    accept;
    logic    push;
    logic    space;
    t_result front_result;
    t_result out_result;

    // input transaction accepted whenever the queue has a free entry
    assign o_ready = space;
    assign accept  = i_valid && space;

    // header tracking and body counting
    clc_front #(
        .LEN_BITS (LEN_BITS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_byte   (i_in_byte),
        .o_push   (push),
        .o_result (front_result)
    );

    // result queue and output handshake
    clc_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_result (front_result),
        .o_space  (space),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_result (out_result)
    );

    assign o_body_byte = out_result.body_byte;
    assign o_last      = out_result.last;
    assign o_empty_msg = out_result.empty_msg;

endmodule

// ===== tb/sv/clc_frame_checker.sv =====
// stream checker for the content-length deframer: predicts results and compares
// depends on clc_pkg for the result struct, phase and separator types
`timescale 1ns / 1ps

module clc_frame_checker #(
    parameter int LEN_BITS = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_ready,
    input  logic [7:0] i_in_byte,
    input  logic       i_out_valid,
    input  logic       i_out_ready,
    input  logic [7:0] i_body_byte,
    input  logic       i_last,
    input  logic       i_empty_msg,
    output int         o_fail_count,
    output int         o_pending,
    output int         o_result_count,
    output int         o_empty_count
);
    import clc_pkg::*;

    localparam logic [LEN_BITS-1:0]  LEN_MAX  = '1;
    localparam logic [8*TAG_LEN-1:0] TAG_TEXT = "content-length:";

    // predicted deframer state
    logic                body_mode;
    t_sep                sep_state;
    int unsigned         tag_pos;
    t_phase              len_phase;
    logic [LEN_BITS-1:0] msg_len;
    logic [LEN_BITS-1:0] body_remaining;

    // results predicted but not yet seen on the output
    t_result expected_results[$];

    int fail_count;
    int result_count;
    int empty_count;

    assign o_fail_count   = fail_count;
    assign o_result_count = result_count;
    assign o_empty_count  = empty_count;

    initial begin
        fail_count   = 0;
        result_count = 0;
        empty_count  = 0;
        o_pending    = 0;
    end

    function automatic logic [7:0] tag_at(input int unsigned pos);
        return TAG_TEXT[8*(TAG_LEN-1-pos) +: 8];
    endfunction

    task automatic clear_header();
        sep_state = SEP_NONE;
        tag_pos   = 0;
        len_phase = PH_TAG;
        msg_len   = '0;
    endtask

    // advance the predicted state by one stream byte, queue any result it causes
    task automatic step_deframer(input logic [7:0] b);
        logic [7:0]          lower;
        logic [LEN_BITS-1:0] len_snapshot;
        longint unsigned     digit;
        t_result             r;
        if (body_mode) begin
            if (body_remaining != '0)
                body_remaining = body_remaining - 1'b1;
            r.body_byte = b;
            r.last      = (body_remaining == '0);
            r.empty_msg = 1'b0;
            expected_results.insert(expected_results.size(), r);
            if (body_remaining == '0) begin
                body_mode = 1'b0;
                clear_header();
            end
        end else begin
            // length field tracking
            lower = (b >= CH_UPA && b <= CH_UPZ) ? b + 8'd32 : b;
            if (len_phase == PH_TAG) begin
                if (lower == tag_at(tag_pos))
                    tag_pos = tag_pos + 1;
                else
                    tag_pos = (lower == tag_at(0)) ? 1 : 0;
                if (tag_pos == TAG_LEN) begin
                    tag_pos   = 0;
                    len_phase = PH_SPACE;
                end
            end else begin
                if (len_phase == PH_SPACE && b != CH_SPACE)
                    len_phase = PH_DIGITS;
                if (len_phase == PH_DIGITS) begin
                    if (b >= CH_ZERO && b <= CH_NINE) begin
                        digit = longint'(b - CH_ZERO);
                        if (longint'(msg_len) > (longint'(LEN_MAX) - digit) / 10)
                            msg_len = LEN_MAX;
                        else
                            msg_len = LEN_BITS'(longint'(msg_len) * 10 + digit);
                    end else begin
                        len_phase = PH_DONE;
                    end
                end
            end

            // blank line detection
            if ((sep_state == SEP_NONE || sep_state == SEP_CRLF) && b == CH_CR) begin
                sep_state = (sep_state == SEP_NONE) ? SEP_CR : SEP_CRLFCR;
            end else if (sep_state == SEP_CR && b == CH_LF) begin
                sep_state = SEP_CRLF;
            end else if (sep_state == SEP_CRLFCR && b == CH_LF) begin
                len_snapshot = msg_len;
                clear_header();
                if (len_snapshot == '0) begin
                    r.body_byte = 8'h00;
                    r.last      = 1'b1;
                    r.empty_msg = 1'b1;
                    expected_results.insert(expected_results.size(), r);
                end else begin
                    body_mode      = 1'b1;
                    body_remaining = len_snapshot;
                end
            end else begin
                sep_state = (b == CH_CR) ? SEP_CR : SEP_NONE;
            end
        end
    endtask

    // predict on accepted input, compare on accepted output
    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            body_mode      = 1'b0;
            body_remaining = '0;
            clear_header();
            expected_results.delete();
        end else begin
            if (i_in_valid && i_in_ready)
                step_deframer(i_in_byte);
            if (i_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    $error("unexpected result transaction: body_byte %h last %b empty_msg %b",
                           i_body_byte, i_last, i_empty_msg);
                    fail_count = fail_count + 1;
                end else begin
                    want = expected_results.pop_front();
                    result_count = result_count + 1;
                    if (want.empty_msg)
                        empty_count = empty_count + 1;
                    if (i_body_byte !== want.body_byte) begin
                        $error("body_byte mismatch: expected %h, actual %h",
                               want.body_byte, i_body_byte);
                        fail_count = fail_count + 1;
                    end
                    if (i_last !== want.last) begin
                        $error("last mismatch: expected %b, actual %b", want.last, i_last);
                        fail_count = fail_count + 1;
                    end
                    if (i_empty_msg !== want.empty_msg) begin
                        $error("empty_msg mismatch: expected %b, actual %b",
                               want.empty_msg, i_empty_msg);
                        fail_count = fail_count + 1;
                    end
                end
            end
        end
        o_pending = expected_results.size();
    end

endmodule

// ===== tb/sv/content_length_deframer_unit_tb.sv =====
// testbench top for the content-length deframer: clock, reset, framed byte stimulus
// depends on clc_pkg, content_length_deframer_unit and clc_frame_checker
`timescale 1ns / 1ps

module content_length_deframer_unit_tb;
    import clc_pkg::*;

    localparam int RANDOM_BYTES  = 1450;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 10;

    typedef enum int {
        RX_STREAM,
        RX_RANDOM,
        RX_STARVED,
        RX_PERIODIC
    } t_rx_mode;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_ready;
    logic [7:0] i_in_byte;
    logic       o_valid;
    logic       i_ready;
    logic [7:0] o_body_byte;
    logic       o_last;
    logic       o_empty_msg;

    int fail_count;
    int pending;
    int results_seen;
    int empty_seen;

    int bytes_sent;
    int burst_left;
    int cycle_count;
    int random_start;

    // bytes of the message being assembled
    logic [7:0] stream_bytes[$];

    content_length_deframer_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_in_byte   (i_in_byte),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_body_byte (o_body_byte),
        .o_last      (o_last),
        .o_empty_msg (o_empty_msg)
    );

    clc_frame_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_valid),
        .i_in_ready     (o_ready),
        .i_in_byte      (i_in_byte),
        .i_out_valid    (o_valid),
        .i_out_ready    (i_ready),
        .i_body_byte    (o_body_byte),
        .i_last         (o_last),
        .i_empty_msg    (o_empty_msg),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_result_count (results_seen),
        .o_empty_count  (empty_seen)
    );

    // 100 MHz clock
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // watchdog
    initial cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count = cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // receiver back-pressure, pattern picked at random from four modes
    initial begin
        t_rx_mode rx_mode;
        int       mode_left;
        rx_mode   = RX_STREAM;
        mode_left = 0;
        i_ready   = 1'b0;
        forever begin
            @(negedge i_clk);
            if (mode_left == 0) begin
                rx_mode   = t_rx_mode'($urandom_range(0, 3));
                mode_left = $urandom_range(20, 150);
            end
            mode_left = mode_left - 1;
            case (rx_mode)
                RX_STREAM:   i_ready = 1'b1;
                RX_RANDOM:   i_ready = 1'($urandom_range(0, 1));
                RX_STARVED:  i_ready = ($urandom_range(0, 3) == 0);
                default:     i_ready = ((mode_left % 8) < 5);
            endcase
        end
    end

    // random header byte, never a CR so a blank line only comes where placed
    function automatic logic [7:0] noise_byte();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        if (b == CH_CR)
            b = 8'h2E;
        return b;
    endfunction

    // append one byte to the message being assembled
    task automatic queue_byte(input logic [7:0] b);
        stream_bytes.insert(stream_bytes.size(), b);
    endtask

    task automatic queue_text(input string s);
        for (int i = 0; i < s.len(); i++)
            queue_byte(s[i]);
    endtask

    task automatic queue_eol(input int count);
        repeat (count) begin
            queue_byte(CH_CR);
            queue_byte(CH_LF);
        end
    endtask

    // tag with each letter in random case
    task automatic queue_tag_mixed();
        string      tag;
        logic [7:0] c;
        tag = "content-length:";
        for (int i = 0; i < tag.len(); i++) begin
            c = tag[i];
            if (c >= 8'h61 && c <= 8'h7A && $urandom_range(0, 1))
                c = c - 8'd32;
            queue_byte(c);
        end
    endtask

    task automatic queue_noise_lines(input int count);
        repeat (count) begin
            repeat ($urandom_range(0, 12))
                queue_byte(noise_byte());
            queue_eol(1);
        end
    endtask

    task automatic queue_body(input int count);
        repeat (count)
            queue_byte(8'($urandom_range(0, 255)));
    endtask

    // one byte transaction, with the sender's bursts and gaps
    task automatic drive_byte(input logic [7:0] b);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                i_valid = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 48);
        end
        burst_left = burst_left - 1;
        i_valid    = 1'b1;
        i_in_byte  = b;
        @(posedge i_clk);
        while (!o_ready)
            @(posedge i_clk);
        @(negedge i_clk);
        bytes_sent = bytes_sent + 1;
    endtask

    task automatic transmit_stream();
        while (stream_bytes.size() > 0)
            drive_byte(stream_bytes.pop_front());
    endtask

    // hold the sender until every predicted result has come out
    task automatic drain_results();
        i_valid = 1'b0;
        while (pending != 0)
            @(negedge i_clk);
    endtask

    // one random message, mostly well formed
    task automatic queue_random_message();
        int kind;
        int body_len;
        int sel;
        kind = $urandom_range(0, 99);
        if (kind < 80) begin
            sel = $urandom_range(0, 99);
            if (sel < 70)
                body_len = $urandom_range(0, 24);
            else if (sel < 95)
                body_len = $urandom_range(25, 120);
            else
                body_len = $urandom_range(121, 400);
            queue_noise_lines($urandom_range(0, 2));
            queue_tag_mixed();
            repeat ($urandom_range(0, 3))
                queue_byte(CH_SPACE);
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 2))
                    queue_byte(CH_ZERO);
            queue_text($sformatf("%0d", body_len));
            if ($urandom_range(0, 4) == 0)
                queue_text(";x");
            queue_eol(1);
            queue_noise_lines($urandom_range(0, 2));
            queue_eol(1);
            queue_body(body_len);
        end else begin
            case ($urandom_range(0, 4))
                // header without any tag
                0: begin
                    queue_noise_lines($urandom_range(1, 3));
                    queue_eol(1);
                end
                // tag followed by a non-digit
                1: begin
                    queue_tag_mixed();
                    repeat ($urandom_range(0, 2))
                        queue_byte(CH_SPACE);
                    case ($urandom_range(0, 2))
                        0:       queue_text("-5");
                        1:       queue_byte(8'h09);
                        default: queue_text("x12");
                    endcase
                    queue_eol(2);
                end
                // tag cut short by the blank line
                2: begin
                    sel = $urandom_range(1, TAG_LEN - 1);
                    queue_text(string'("content-length:"));
                    repeat (TAG_LEN - sel)
                        void'(stream_bytes.pop_back());
                    queue_eol(2);
                end
                // raw garbage of any byte value
                3: begin
                    repeat ($urandom_range(1, 30))
                        queue_byte(8'($urandom_range(0, 255)));
                    queue_eol(2);
                end
                // second tag is ignored
                default: begin
                    body_len = $urandom_range(1, 9);
                    queue_tag_mixed();
                    queue_text($sformatf(" %0d", body_len));
                    queue_eol(1);
                    queue_tag_mixed();
                    queue_text(" 250");
                    queue_eol(2);
                    queue_body(body_len);
                end
            endcase
        end
    endtask

    initial begin
        i_rst_n    = 1'b0;
        i_valid    = 1'b0;
        i_in_byte  = 8'h00;
        bytes_sent = 0;
        burst_left = 0;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: upper-case tag, body with extreme bytes and line breaks
        queue_text("CONTENT-LENGTH:4");
        queue_eol(2);
        queue_byte(8'h00);
        queue_byte(8'hFF);
        queue_byte(CH_CR);
        queue_byte(CH_LF);
        // explicit zero length
        queue_text("content-length: 0");
        queue_eol(2);
        // no tag at all
        queue_eol(2);
        // tag with no digits
        queue_text("Content-length:");
        queue_eol(2);
        // sign and tab end the value with nothing read
        queue_text("content-length: -5");
        queue_eol(2);
        queue_text("content-length:");
        queue_byte(8'h09);
        queue_text("7");
        queue_eol(2);
        // letter after a digit keeps the digit
        queue_text("Content-Length:  2x9");
        queue_eol(2);
        queue_text("hi");
        // repeated tag
        queue_text("content-length: 1");
        queue_eol(1);
        queue_text("Content-Length: 5");
        queue_eol(2);
        queue_text("Z");
        // partial tag broken by the blank line
        queue_text("conten");
        queue_eol(2);
        queue_text("-length: 3");
        queue_eol(2);
        // restart of a partial match, leading zeros
        queue_text("content-lcontent-length:007");
        queue_eol(2);
        queue_body(7);
        // lone CRs around the blank line, odd header bytes
        queue_byte(8'h00);
        queue_byte(8'hFF);
        queue_text("@[AZaz`{");
        queue_byte(CH_CR);
        queue_byte(CH_CR);
        queue_byte(CH_LF);
        queue_byte(CH_CR);
        queue_text("content-length: 1/");
        queue_byte(CH_CR);
        queue_byte(CH_CR);
        queue_byte(CH_LF);
        queue_byte(CH_CR);
        queue_byte(CH_LF);
        queue_body(1);
        // colon right after digits
        queue_text("content-length: 19:");
        queue_eol(2);
        queue_body(19);
        transmit_stream();
        drain_results();

        // random messages with occasional full drains
        random_start = bytes_sent;
        while (bytes_sent - random_start < RANDOM_BYTES) begin
            queue_random_message();
            transmit_stream();
            if ($urandom_range(0, 24) == 0)
                drain_results();
        end

        // saturating length last: the block stays in the body from here on
        queue_text("Content-Length: 42949672959");
        queue_eol(2);
        queue_body(40);
        transmit_stream();

        i_valid = 1'b0;
        while (pending != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);

        $display("stream of %0d bytes, %0d result transactions checked (%0d empty messages)",
                 bytes_sent, results_seen, empty_seen);
        $display("covered tag search, length parsing, saturation and body framing");
        if (fail_count == 0 && pending == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
